FILE: hdl/trcu_pkg.sv
// types and constants for the ring road car update unit
`timescale 1ns / 1ps

package trcu_pkg;

  localparam int POS_W  = 11;
  localparam int VEL_W  = 4;
  localparam int GAP_W  = 10;
  localparam int CAR_W  = 4;
  localparam int DRAW_W = 7;
  localparam int THR_W  = 7;
  localparam int USE_W  = 5;
  localparam int CFG_W  = 11;
  localparam int CFGI_W = 3;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef enum logic [CFGI_W-1:0] {
    CFG_ROAD_LENGTH   = 3'd0,
    CFG_MAX_VELOCITY  = 3'd1,
    CFG_BRAKE_MOVING  = 3'd2,
    CFG_BRAKE_STOPPED = 3'd3,
    CFG_CARS_IN_USE   = 3'd4,
    CFG_MEASURE_SITE  = 3'd5
  } cfg_index_t;

  localparam logic [POS_W-1:0]  RST_ROAD_LENGTH   = 11'd100;
  localparam logic [VEL_W-1:0]  RST_MAX_VELOCITY  = 4'd5;
  localparam logic [THR_W-1:0]  RST_BRAKE_MOVING  = 7'd2;
  localparam logic [THR_W-1:0]  RST_BRAKE_STOPPED = 7'd75;
  localparam logic [USE_W-1:0]  RST_CARS_IN_USE   = 5'd10;
  localparam logic [POS_W-1:0]  RST_MEASURE_SITE  = 11'd10;

  localparam logic [GAP_W-1:0]  GAP_SAT = '1;

endpackage

FILE: hdl/trcu_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module trcu_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/traffic_ring_car_update_unit.sv
// ring road traffic automaton, one car update or load per beat
//
//  channel  signals                                         direction
//  in       in_valid/in_ready, operation .. end_of_tick     beat in
//  out      out_valid/out_ready, car_number .. tick_committed  beat out
//  cfg      cfg_write_enable, cfg_index, cfg_data           register write
//
// an update runs a gap search that reads one car position per cycle
// from the current ram, and end_of_tick adds a next-to-current copy sweep.
// rst is synchronous; registers go to their reset values, car rams are
// undefined until loaded. in_ready is high only while idle; a waiting out
// beat does not block the next item until that item is ready to finish.
`timescale 1ns / 1ps

module traffic_ring_car_update_unit
  import trcu_pkg::*;
#(
  parameter int NUM_CARS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_enable,
  input  logic [CFGI_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              operation,
  input  logic [CAR_W-1:0]  car_index,
  input  logic [POS_W-1:0]  load_position,
  input  logic [VEL_W-1:0]  load_velocity,
  input  logic [DRAW_W-1:0] random_draw,
  input  logic              end_of_tick,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CAR_W-1:0]  car_number,
  output logic [POS_W-1:0]  new_position,
  output logic [VEL_W-1:0]  new_velocity,
  output logic [GAP_W-1:0]  gap_ahead,
  output logic              passed_measure,
  output logic              tick_committed
);

  localparam int IDX_W = $clog2(NUM_CARS);
  localparam int CNT_W = $clog2(NUM_CARS + 1);
  localparam int CW    = (CNT_W > USE_W) ? CNT_W : USE_W;
  localparam int WORD_W = POS_W + VEL_W;
  localparam logic [CW-1:0] NCARS = CW'(NUM_CARS);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_FETCH, S_POS, S_SCAN, S_SPEED, S_MOVE, S_COMMIT, S_DONE
  } state_t;

  state_t state;

  logic [POS_W-1:0] road_length;
  logic [VEL_W-1:0] max_velocity;
  logic [THR_W-1:0] brake_threshold_moving;
  logic [THR_W-1:0] brake_threshold_stopped;
  logic [USE_W-1:0] cars_in_use;
  logic [POS_W-1:0] measure_site;

  logic [IDX_W-1:0]  car;
  logic [POS_W-1:0]  lpos;
  logic [VEL_W-1:0]  lvel;
  logic [DRAW_W-1:0] draw;
  logic              eot;

  logic [POS_W-1:0] x;
  logic [VEL_W-1:0] v;
  logic [POS_W-1:0] gap;
  logic [POS_W-1:0] m1;
  logic [POS_W-1:0] m2;
  logic [CW-1:0]    cnt;
  logic             pend;
  logic [IDX_W-1:0] wr_idx;
  logic [VEL_W-1:0] vnew;
  logic [POS_W-1:0] res_pos;
  logic             res_passed;

  logic [IDX_W-1:0]  car_mod;
  logic [CW-1:0]     n_active;
  logic [CW-1:0]     use_ext;

  logic              cur_we;
  logic [IDX_W-1:0]  cur_waddr;
  logic [WORD_W-1:0] cur_wdata;
  logic [IDX_W-1:0]  cur_raddr;
  logic [WORD_W-1:0] cur_rdata;
  logic              nxt_we;
  logic [WORD_W-1:0] nxt_wdata;
  logic [IDX_W-1:0]  nxt_raddr;
  logic [WORD_W-1:0] nxt_rdata;

  logic signed [POS_W+1:0] diff;
  logic [POS_W-1:0]        fwd_dist;
  logic [POS_W-1:0]        m1_next;
  logic [POS_W-1:0]        m2_next;

  logic [THR_W-1:0] thr;
  logic [VEL_W:0]   v_inc;
  logic [VEL_W-1:0] v1;
  logic [VEL_W-1:0] v2;
  logic [VEL_W-1:0] v_next;

  logic [POS_W:0]   sum;
  logic [POS_W:0]   wrapped;
  logic [POS_W-1:0] npos;
  logic             passed_next;

  always_comb begin
    car_mod = '0;
    for (int k = 0; k < (1 << CAR_W); k++) begin
      if (car_index == CAR_W'(k)) begin
        car_mod = IDX_W'(k % NUM_CARS);
      end
    end
  end

  assign use_ext  = CW'(cars_in_use);
  assign n_active = (use_ext > NCARS) ? NCARS : use_ext;

  // distance unit shared across the scan
  always_comb begin
    diff = $signed({2'b00, cur_rdata[WORD_W-1:VEL_W]}) - $signed({2'b00, x});
    if (diff < 0) begin
      diff = diff + $signed({2'b00, road_length});
    end
    if (diff < 0) begin
      diff = '0;
    end
    fwd_dist = diff[POS_W-1:0];
    m1_next = m1;
    m2_next = m2;
    if (fwd_dist < m1) begin
      m2_next = m1;
      m1_next = fwd_dist;
    end else if (fwd_dist < m2) begin
      m2_next = fwd_dist;
    end
  end

  always_comb begin
    thr   = (v == '0) ? brake_threshold_stopped : brake_threshold_moving;
    v_inc = {1'b0, v} + 1'b1;
    v1    = v;
    if (v < max_velocity && gap > POS_W'(v_inc)) begin
      v1 = v_inc[VEL_W-1:0];
    end
    v2 = v1;
    if (gap <= POS_W'(v1) && v1 != '0) begin
      v2 = (gap != '0) ? VEL_W'(gap - 1'b1) : '0;
    end
    v_next = v2;
    if (THR_W'(draw) < thr && v2 != '0) begin
      v_next = v2 - 1'b1;
    end
  end

  always_comb begin
    sum     = {1'b0, x} + (POS_W+1)'(vnew);
    wrapped = sum - {1'b0, road_length};
    npos    = (sum <= {1'b0, road_length}) ? sum[POS_W-1:0] : wrapped[POS_W-1:0];
    passed_next = (x <= measure_site) && (sum > {1'b0, measure_site});
  end

  always_comb begin
    cur_we    = 1'b0;
    cur_waddr = car;
    cur_wdata = {lpos, lvel};
    nxt_we    = 1'b0;
    nxt_wdata = {lpos, lvel};
    cur_raddr = car;
    nxt_raddr = cnt[IDX_W-1:0];
    case (state)
      S_LOAD: begin
        cur_we = 1'b1;
        nxt_we = 1'b1;
      end
      S_SCAN: begin
        cur_raddr = cnt[IDX_W-1:0];
      end
      S_MOVE: begin
        nxt_we    = 1'b1;
        nxt_wdata = {npos, vnew};
      end
      S_COMMIT: begin
        cur_we    = pend;
        cur_waddr = wr_idx;
        cur_wdata = nxt_rdata;
      end
      default: begin
      end
    endcase
  end

  trcu_ram #(.WIDTH(WORD_W), .DEPTH(NUM_CARS)) u_cur_ram (
    .clk   (clk),
    .we    (cur_we),
    .waddr (cur_waddr),
    .wdata (cur_wdata),
    .raddr (cur_raddr),
    .rdata (cur_rdata)
  );

  trcu_ram #(.WIDTH(WORD_W), .DEPTH(NUM_CARS)) u_nxt_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (car),
    .wdata (nxt_wdata),
    .raddr (nxt_raddr),
    .rdata (nxt_rdata)
  );

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      road_length             <= RST_ROAD_LENGTH;
      max_velocity            <= RST_MAX_VELOCITY;
      brake_threshold_moving  <= RST_BRAKE_MOVING;
      brake_threshold_stopped <= RST_BRAKE_STOPPED;
      cars_in_use             <= RST_CARS_IN_USE;
      measure_site            <= RST_MEASURE_SITE;
    end else if (cfg_write_enable) begin
      case (cfg_index_t'(cfg_index))
        CFG_ROAD_LENGTH:   road_length             <= cfg_data;
        CFG_MAX_VELOCITY:  max_velocity            <= cfg_data[VEL_W-1:0];
        CFG_BRAKE_MOVING:  brake_threshold_moving  <= cfg_data[THR_W-1:0];
        CFG_BRAKE_STOPPED: brake_threshold_stopped <= cfg_data[THR_W-1:0];
        CFG_CARS_IN_USE:   cars_in_use             <= cfg_data[USE_W-1:0];
        CFG_MEASURE_SITE:  measure_site            <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      cnt       <= '0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            car   <= car_mod;
            lpos  <= load_position;
            lvel  <= load_velocity;
            draw  <= random_draw;
            eot   <= end_of_tick;
            state <= (operation == OP_LOAD) ? S_LOAD : S_FETCH;
          end
        end
        S_LOAD: begin
          res_pos    <= lpos;
          vnew       <= lvel;
          gap        <= '0;
          res_passed <= 1'b0;
          cnt        <= '0;
          pend       <= 1'b0;
          state      <= eot ? S_COMMIT : S_DONE;
        end
        S_FETCH: begin
          state <= S_POS;
        end
        S_POS: begin
          x    <= cur_rdata[WORD_W-1:VEL_W];
          v    <= cur_rdata[VEL_W-1:0];
          m1   <= '1;
          m2   <= '1;
          cnt  <= '0;
          pend <= 1'b0;
          if (n_active < CW'(2)) begin
            gap   <= road_length;
            state <= S_SPEED;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (pend) begin
            m1 <= m1_next;
            m2 <= m2_next;
          end
          if (cnt < n_active) begin
            cnt  <= cnt + 1'b1;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              gap   <= m2;
              state <= S_SPEED;
            end
          end
        end
        S_SPEED: begin
          vnew  <= v_next;
          state <= S_MOVE;
        end
        S_MOVE: begin
          res_pos    <= npos;
          res_passed <= passed_next;
          cnt        <= '0;
          pend       <= 1'b0;
          state      <= eot ? S_COMMIT : S_DONE;
        end
        S_COMMIT: begin
          wr_idx <= cnt[IDX_W-1:0];
          if (cnt < NCARS) begin
            cnt  <= cnt + 1'b1;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            car_number     <= CAR_W'(car);
            new_position   <= res_pos;
            new_velocity   <= vnew;
            gap_ahead      <= (gap > POS_W'(GAP_SAT)) ? GAP_SAT : gap[GAP_W-1:0];
            passed_measure <= res_passed;
            tick_committed <= eot;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_no_cur_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !cur_we)
    else $error("current ram written during gap search");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> cnt <= n_active)
    else $error("gap search ran past active cars");

  a_dual_write_on_load: assert property (@(posedge clk) disable iff (rst)
    cur_we && nxt_we |-> state == S_LOAD)
    else $error("both rams written outside a load");

endmodule

FILE: tb/tb_traffic_ring_car_update_unit.sv
// testbench for the ring road car update unit: directed and random beats checked against a predictor
`timescale 1ns / 1ps

module tb_traffic_ring_car_update_unit;
  import trcu_pkg::*;

  localparam int CARS        = 16;
  localparam int LIMIT       = 600000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT     = 450;
  localparam int PHASE_BEATS = 140;
  localparam int DRAIN       = 64;

  typedef struct packed {
    logic              op;
    logic [CAR_W-1:0]  car;
    logic [POS_W-1:0]  lpos;
    logic [VEL_W-1:0]  lvel;
    logic [DRAW_W-1:0] draw;
    logic              eot;
  } car_beat_t;

  typedef struct packed {
    logic [CAR_W-1:0] car;
    logic [POS_W-1:0] pos;
    logic [VEL_W-1:0] vel;
    logic [GAP_W-1:0] gap;
    logic             passed;
    logic             commit;
  } car_result_t;

  typedef struct {
    car_beat_t   beat;
    bit          typed;
    car_result_t want;
  } opening_row_t;

  typedef struct {
    int road;
    int vmax;
    int thr_mov;
    int thr_stop;
    int used;
    int meas;
  } road_setup_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_write_enable;
  logic [CFGI_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic              operation;
  logic [CAR_W-1:0]  car_index;
  logic [POS_W-1:0]  load_position;
  logic [VEL_W-1:0]  load_velocity;
  logic [DRAW_W-1:0] random_draw;
  logic              end_of_tick;
  logic              out_valid;
  logic              out_ready;
  logic [CAR_W-1:0]  car_number;
  logic [POS_W-1:0]  new_position;
  logic [VEL_W-1:0]  new_velocity;
  logic [GAP_W-1:0]  gap_ahead;
  logic              passed_measure;
  logic              tick_committed;

  traffic_ring_car_update_unit i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .car_index        (car_index),
    .load_position    (load_position),
    .load_velocity    (load_velocity),
    .random_draw      (random_draw),
    .end_of_tick      (end_of_tick),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .car_number       (car_number),
    .new_position     (new_position),
    .new_velocity     (new_velocity),
    .gap_ahead        (gap_ahead),
    .passed_measure   (passed_measure),
    .tick_committed   (tick_committed)
  );

  always #1 clk = ~clk;

  // road state and registers as the predictor sees them
  logic [POS_W-1:0] cur_pos [CARS];
  logic [VEL_W-1:0] cur_vel [CARS];
  logic [POS_W-1:0] nxt_pos [CARS];
  logic [VEL_W-1:0] nxt_vel [CARS];
  logic [POS_W-1:0] road_len   = RST_ROAD_LENGTH;
  logic [VEL_W-1:0] speed_cap  = RST_MAX_VELOCITY;
  logic [THR_W-1:0] thr_moving = RST_BRAKE_MOVING;
  logic [THR_W-1:0] thr_halted = RST_BRAKE_STOPPED;
  logic [USE_W-1:0] used_cars  = RST_CARS_IN_USE;
  logic [POS_W-1:0] meas_site  = RST_MEASURE_SITE;

  car_result_t car_results_due [$];
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          beats_sent     = 0;
  int          burst_left     = 4;
  bit          hold_request   = 1'b0;

  opening_row_t opening_rows [21] = '{
    '{'{OP_LOAD, 4'd0, 11'd1, 4'd0, 7'd0, 1'b0}, 1'b1, '{4'd0, 11'd1, 4'd0, 10'd0, 1'b0, 1'b0}},
    '{'{OP_LOAD, 4'd1, 11'd1024, 4'd15, 7'd0, 1'b0}, 1'b1,
      '{4'd1, 11'd1024, 4'd15, 10'd0, 1'b0, 1'b0}},
    '{'{OP_LOAD, 4'd2, 11'd100, 4'd5, 7'd0, 1'b0}, 1'b1,
      '{4'd2, 11'd100, 4'd5, 10'd0, 1'b0, 1'b0}},
    '{'{OP_LOAD, 4'd3, 11'd8, 4'd2, 7'd0, 1'b0}, 1'b1, '{4'd3, 11'd8, 4'd2, 10'd0, 1'b0, 1'b0}},
    '{'{OP_LOAD, 4'd4, 11'd20, 4'd4, 7'd0, 1'b0}, 1'b1, '{4'd4, 11'd20, 4'd4, 10'd0, 1'b0, 1'b0}},
    '{'{OP_LOAD, 4'd5, 11'd40, 4'd1, 7'd0, 1'b0}, 1'b1, '{4'd5, 11'd40, 4'd1, 10'd0, 1'b0, 1'b0}},
    '{'{OP_LOAD, 4'd6, 11'd40, 4'd3, 7'd0, 1'b0}, 1'b1, '{4'd6, 11'd40, 4'd3, 10'd0, 1'b0, 1'b0}},
    '{'{OP_LOAD, 4'd7, 11'd60, 4'd5, 7'd0, 1'b0}, 1'b1, '{4'd7, 11'd60, 4'd5, 10'd0, 1'b0, 1'b0}},
    '{'{OP_LOAD, 4'd8, 11'd75, 4'd0, 7'd0, 1'b0}, 1'b1, '{4'd8, 11'd75, 4'd0, 10'd0, 1'b0, 1'b0}},
    '{'{OP_LOAD, 4'd9, 11'd90, 4'd3, 7'd0, 1'b0}, 1'b1, '{4'd9, 11'd90, 4'd3, 10'd0, 1'b0, 1'b0}},
    // commit on a load
    '{'{OP_LOAD, 4'd15, 11'd512, 4'd7, 7'd0, 1'b1}, 1'b1,
      '{4'd15, 11'd512, 4'd7, 10'd0, 1'b0, 1'b1}},
    '{'{OP_UPDATE, 4'd0, 11'd0, 4'd0, 7'd74, 1'b0}, 1'b0, '0},
    '{'{OP_UPDATE, 4'd8, 11'd0, 4'd0, 7'd75, 1'b0}, 1'b0, '0},
    '{'{OP_UPDATE, 4'd2, 11'd0, 4'd0, 7'd1, 1'b0}, 1'b0, '0},
    '{'{OP_UPDATE, 4'd3, 11'd0, 4'd0, 7'd99, 1'b0}, 1'b0, '0},
    '{'{OP_UPDATE, 4'd5, 11'd0, 4'd0, 7'd50, 1'b0}, 1'b0, '0},
    '{'{OP_UPDATE, 4'd6, 11'd0, 4'd0, 7'd0, 1'b0}, 1'b0, '0},
    '{'{OP_UPDATE, 4'd1, 11'd0, 4'd0, 7'd2, 1'b0}, 1'b0, '0},
    '{'{OP_UPDATE, 4'd7, 11'd0, 4'd0, 7'd64, 1'b0}, 1'b0, '0},
    '{'{OP_UPDATE, 4'd9, 11'd0, 4'd0, 7'd99, 1'b1}, 1'b0, '0},
    '{'{OP_UPDATE, 4'd0, 11'd0, 4'd0, 7'd0, 1'b1}, 1'b0, '0}
  };

  road_setup_t corner_setups [4] = '{
    '{1024, 15, 100, 100, 1, 1024},
    '{2, 1, 0, 0, 16, 0},
    '{30, 5, 20, 50, 16, 15},
    '{1024, 15, 0, 0, 16, 500}
  };

  function automatic int gap_to_leader(int x);
    int n, len, d, m1, m2, i;
    n = (int'(used_cars) > CARS) ? CARS : int'(used_cars);
    len = int'(road_len);
    if (n < 2) return len;
    m1 = 32'h7fffffff;
    m2 = m1;
    for (i = 0; i < n; i++) begin
      d = int'(cur_pos[i]) - x;
      if (d < 0) d += len;
      if (d < 0) d = 0;
      if (d < m1) begin
        m2 = m1;
        m1 = d;
      end else if (d < m2) begin
        m2 = d;
      end
    end
    return m2;
  endfunction

  function automatic car_result_t advance_car(car_beat_t b);
    car_result_t r;
    int x, v, d, thr, sum, np, i;
    r = '0;
    r.car = b.car;
    r.commit = b.eot;
    if (b.op == OP_LOAD) begin
      cur_pos[b.car] = b.lpos;
      cur_vel[b.car] = b.lvel;
      nxt_pos[b.car] = b.lpos;
      nxt_vel[b.car] = b.lvel;
      r.pos = b.lpos;
      r.vel = b.lvel;
    end else begin
      x = int'(cur_pos[b.car]);
      v = int'(cur_vel[b.car]);
      d = gap_to_leader(x);
      thr = (v == 0) ? int'(thr_halted) : int'(thr_moving);
      if (v < int'(speed_cap) && d > v + 1) v = v + 1;
      if (d <= v && v > 0) v = (d > 0) ? d - 1 : 0;
      if (int'(b.draw) < thr && v > 0) v = v - 1;
      sum = x + v;
      r.passed = (x <= int'(meas_site)) && (sum > int'(meas_site));
      np = (sum <= int'(road_len)) ? sum : sum - int'(road_len);
      r.pos = np[POS_W-1:0];
      r.vel = v[VEL_W-1:0];
      r.gap = (d > int'(GAP_SAT)) ? GAP_SAT : d[GAP_W-1:0];
      nxt_pos[b.car] = r.pos;
      nxt_vel[b.car] = r.vel;
    end
    if (b.eot) begin
      for (i = 0; i < CARS; i++) begin
        cur_pos[i] = nxt_pos[i];
        cur_vel[i] = nxt_vel[i];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // one beat on the input channel; the sender idles in bursts
  task automatic put_beat(input car_beat_t b, input bit typed = 1'b0,
                          input car_result_t want = '0);
    car_result_t r;
    @(negedge clk);
    in_valid      <= 1'b1;
    operation     <= b.op;
    car_index     <= b.car;
    load_position <= b.lpos;
    load_velocity <= b.lvel;
    random_draw   <= b.draw;
    end_of_tick   <= b.eot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = advance_car(b);
    car_results_due.push_back(typed ? want : r);
    beats_sent++;
    if (beats_sent == HOLD_AT) hold_request = 1'b1;
    burst_left--;
    if (burst_left <= 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 30)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
    end
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (car_results_due.size() != 0 || !in_ready) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input int val);
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= val[CFG_W-1:0];
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    case (idx)
      CFG_ROAD_LENGTH:   road_len   = val[POS_W-1:0];
      CFG_MAX_VELOCITY:  speed_cap  = val[VEL_W-1:0];
      CFG_BRAKE_MOVING:  thr_moving = val[THR_W-1:0];
      CFG_BRAKE_STOPPED: thr_halted = val[THR_W-1:0];
      CFG_CARS_IN_USE:   used_cars  = val[USE_W-1:0];
      CFG_MEASURE_SITE:  meas_site  = val[POS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setup(input road_setup_t s);
    write_reg(CFG_ROAD_LENGTH, s.road);
    write_reg(CFG_MAX_VELOCITY, s.vmax);
    write_reg(CFG_BRAKE_MOVING, s.thr_mov);
    write_reg(CFG_BRAKE_STOPPED, s.thr_stop);
    write_reg(CFG_CARS_IN_USE, s.used);
    write_reg(CFG_MEASURE_SITE, s.meas);
  endtask

  // reload every car, then mostly whole ticks with some stray beats
  task automatic drive_traffic(input int budget);
    car_beat_t b;
    int count, c, n;
    count = 0;
    n = (int'(used_cars) > CARS) ? CARS : int'(used_cars);
    for (c = 0; c < CARS; c++) begin
      b = '0;
      b.op = OP_LOAD;
      b.car = c[CAR_W-1:0];
      b.lpos = POS_W'(($urandom_range(0, 9) == 0) ? $urandom_range(1, 1024)
                                                  : $urandom_range(1, int'(road_len)));
      b.lvel = VEL_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                  : $urandom_range(0, int'(speed_cap)));
      b.draw = DRAW_W'($urandom_range(0, 99));
      b.eot = (c == CARS - 1);
      put_beat(b);
      count++;
    end
    while (count < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        b.op   = 1'($urandom_range(0, 1));
        b.car  = CAR_W'($urandom_range(0, CARS - 1));
        b.lpos = POS_W'($urandom_range(1, 1024));
        b.lvel = VEL_W'($urandom_range(0, 15));
        b.draw = DRAW_W'($urandom_range(0, 99));
        b.eot  = ($urandom_range(0, 3) == 0);
        put_beat(b);
        count++;
      end else begin
        for (c = 0; c < n; c++) begin
          b = '0;
          b.op = OP_UPDATE;
          b.car = c[CAR_W-1:0];
          b.lpos = POS_W'($urandom_range(1, 1024));
          b.lvel = VEL_W'($urandom_range(0, 15));
          b.draw = DRAW_W'($urandom_range(0, 99));
          b.eot = (c == n - 1);
          put_beat(b);
          count++;
        end
      end
    end
  endtask

  // receiver: ready runs and stalls, plus one long hold-off
  initial begin : receiver
    int left;
    bit stalled;
    bit hold_done;
    left = 0;
    stalled = 1'b0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        left = 0;
      end else begin
        if (left <= 0) begin
          if ($urandom_range(0, 7) == 0) begin
            stalled = 1'b0;
            left = 200;
          end else begin
            stalled = ($urandom_range(0, 2) == 0);
            left = stalled ? $urandom_range(1, 6) : $urandom_range(1, 40);
          end
        end
        left--;
        out_ready <= !stalled;
      end
    end
  end

  always @(posedge clk) begin : result_check
    car_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (car_results_due.size() == 0) begin
        report_mismatch("out beat with nothing expected");
      end else begin
        want = car_results_due.pop_front();
        if (car_number !== want.car)
          report_mismatch($sformatf("car_number %0d, want %0d", car_number, want.car));
        if (new_position !== want.pos)
          report_mismatch($sformatf("car %0d new_position %0d, want %0d",
                                    want.car, new_position, want.pos));
        if (new_velocity !== want.vel)
          report_mismatch($sformatf("car %0d new_velocity %0d, want %0d",
                                    want.car, new_velocity, want.vel));
        if (gap_ahead !== want.gap)
          report_mismatch($sformatf("car %0d gap_ahead %0d, want %0d",
                                    want.car, gap_ahead, want.gap));
        if (passed_measure !== want.passed)
          report_mismatch($sformatf("car %0d passed_measure %0b, want %0b",
                                    want.car, passed_measure, want.passed));
        if (tick_committed !== want.commit)
          report_mismatch($sformatf("car %0d tick_committed %0b, want %0b",
                                    want.car, tick_committed, want.commit));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("[traffic_ring_car_update_unit] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    road_setup_t s;
    int i, p, waited;
    rst              = 1'b1;
    cfg_write_enable = 1'b0;
    cfg_index        = CFG_ROAD_LENGTH;
    cfg_data         = '0;
    in_valid         = 1'b0;
    operation        = OP_LOAD;
    car_index        = '0;
    load_position    = '0;
    load_velocity    = '0;
    random_draw      = '0;
    end_of_tick      = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < $size(opening_rows); i++)
      put_beat(opening_rows[i].beat, opening_rows[i].typed, opening_rows[i].want);

    for (p = 0; p < 8; p++) begin
      drop_valid();
      wait_idle();
      if (p < 4) begin
        s = corner_setups[p];
      end else begin
        s.road = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 1024) : $urandom_range(8, 120);
        s.vmax = $urandom_range(1, 15);
        s.thr_mov = $urandom_range(0, 100);
        s.thr_stop = $urandom_range(0, 100);
        s.used = $urandom_range(1, 16);
        s.meas = $urandom_range(0, s.road);
      end
      apply_setup(s);
      drive_traffic(PHASE_BEATS);
    end
    drop_valid();

    waited = 0;
    while (car_results_due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN) @(posedge clk);
    if (car_results_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", car_results_due.size()));
    if (mismatch_count == 0) begin
      $display("[traffic_ring_car_update_unit] OK");
    end else begin
      $display("[traffic_ring_car_update_unit] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/trcu_pkg.sv
hdl/trcu_ram.sv
hdl/traffic_ring_car_update_unit.sv
tb/tb_traffic_ring_car_update_unit.sv
